// ----- design/ovt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ovt_pkg - shared definitions for the ordered value table engine
// Table geometry, field widths, request and status codes, cell command.
// ----------------------------------------------------------------------------
package ovt_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam int DATA_W = 32;
	localparam int MODE_W = 3;
	localparam int POS_W  = 7;
	localparam int STAT_W = 2;
	localparam int FIDX_W = 6;
	localparam int ECNT_W = 7;

	// common width for position versus count compares
	localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

	typedef logic [DATA_W-1:0] data_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_APPEND = 3'd1;
	localparam logic [MODE_W-1:0] MODE_DELETE = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SEARCH = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SORT   = 3'd4;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd5;

	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE   = 2'd2;
	localparam logic [STAT_W-1:0] ST_MISSING = 2'd3;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INS,
		CELL_DEL,
		CELL_SORT
	} cell_op_t;

	// broadcast to every cell of the row
	typedef struct packed {
		cell_op_t op;
		logic     parity;
		cnt_t     pos;
		data_t    value;
		cnt_t     count;
	} cell_cmd_t;

	function automatic logic greater_signed(input data_t a, input data_t b);
		return $signed(a) > $signed(b);
	endfunction

endpackage
`default_nettype wire

// ----- design/ovt_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ovt_cell - one slot of the table row
// Holds one entry; shifts from a neighbor on insert or delete and does one
// compare-exchange with a neighbor per odd-even sort phase.
// ----------------------------------------------------------------------------
module ovt_cell (
	input  logic                      clk,
	input  logic [ovt_pkg::IDX_W-1:0] idx,
	input  ovt_pkg::cell_cmd_t        cmd,
	input  ovt_pkg::data_t            left,
	input  ovt_pkg::data_t            right,
	output ovt_pkg::data_t            entry,
	output logic                      match
);
	import ovt_pkg::*;

	data_t entry_q;
	data_t entry_d;
	cnt_t  idx_c;
	cnt_t  idx_n;

	assign idx_c = CNT_W'(idx);
	assign idx_n = idx_c + 1'b1;

	always_comb begin
		entry_d = entry_q;
		case (cmd.op)
			CELL_INS: begin
				if (idx_c > cmd.pos) begin
					entry_d = left;
				end else if (idx_c == cmd.pos) begin
					entry_d = cmd.value;
				end
			end
			CELL_DEL: begin
				if (idx_c >= cmd.pos) begin
					entry_d = right;
				end
			end
			CELL_SORT: begin
				if (idx[0] == cmd.parity) begin
					// lower member of the pair: keep the minimum
					if (idx_n < cmd.count && greater_signed(entry_q, right)) begin
						entry_d = right;
					end
				end else begin
					// upper member of the pair: keep the maximum
					if (idx_c < cmd.count && idx_c != '0 && greater_signed(left, entry_q)) begin
						entry_d = left;
					end
				end
			end
			default: begin
				entry_d = entry_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign entry = entry_q;
	assign match = (idx_c < cmd.count) && (entry_q == cmd.value);

endmodule
`default_nettype wire

// ----- design/ordered_value_table_engine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_value_table_engine - packed table of signed values in a cell row
// Insert, append, delete, search, sort ascending and clear on a table of
// TABLE_DEPTH signed 32-bit entries; one result per request.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake             payload
//   request  in         in_valid / in_ready   mode, value, position
//   result   out        out_valid / out_ready status, found_index, entry_count
//
// Insert, append, delete, clear and unused modes answer at once: the output
// register loads at the transfer edge and shows the result in the next cycle.
// Search captures the match vector at the transfer edge, then scans it one
// bit per cycle up to the lowest match; with no match the first scan step
// posts the missing status.
// Sort answers at once for fewer than two entries; otherwise it runs one
// odd-even transposition phase of the cell row per cycle after the transfer.
// Reset clears the count and control state only; entries stay as they are.
// A new request is taken only when idle and the output register is empty or
// being emptied in the same cycle.
// ----------------------------------------------------------------------------
module ordered_value_table_engine (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [ovt_pkg::MODE_W-1:0] mode,
	input  logic signed [ovt_pkg::DATA_W-1:0] value,
	input  logic [ovt_pkg::POS_W-1:0]  position,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [ovt_pkg::STAT_W-1:0] status,
	output logic [ovt_pkg::FIDX_W-1:0] found_index,
	output logic [ovt_pkg::ECNT_W-1:0] entry_count
);
	import ovt_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SRT  = 3'b010,
		ST_SCAN = 3'b100
	} state_t;

	state_t                  state_q;
	cnt_t                    count_q;
	cnt_t                    ph_q;
	logic [IDX_W-1:0]        idx_q;
	logic [TABLE_DEPTH-1:0]  mvec_q;
	logic                    out_valid_q;
	logic [STAT_W-1:0]       status_q;
	logic [FIDX_W-1:0]       found_q;
	logic [ECNT_W-1:0]       ecnt_q;

	cell_cmd_t               cmd;
	data_t                   row  [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0]  mvec;

	logic                    acc;
	logic                    res_now;
	logic [STAT_W-1:0]       res_stat;
	cnt_t                    cnt_next;
	logic                    go_sort;
	logic                    go_scan;
	logic                    full;
	logic [CMP_W-1:0]        pos_ext;
	logic [CMP_W-1:0]        cnt_ext;

	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign acc      = in_valid && in_ready;
	assign full     = (count_q == CNT_W'(TABLE_DEPTH));
	assign pos_ext  = CMP_W'(position);
	assign cnt_ext  = CMP_W'(count_q);

	// decode the request and build the command for the cell row
	always_comb begin
		cmd.op     = CELL_HOLD;
		cmd.parity = ph_q[0];
		cmd.pos    = CNT_W'(position);
		cmd.value  = data_t'(value);
		cmd.count  = count_q;
		res_now    = 1'b0;
		res_stat   = ST_OK;
		cnt_next   = count_q;
		go_sort    = 1'b0;
		go_scan    = 1'b0;
		if (acc) begin
			case (mode)
				MODE_INSERT, MODE_APPEND: begin
					res_now = 1'b1;
					if (mode == MODE_APPEND) begin
						cmd.pos = count_q;
					end
					if (full) begin
						res_stat = ST_FULL;
					end else if (mode == MODE_INSERT && pos_ext > cnt_ext) begin
						res_stat = ST_RANGE;
					end else begin
						cmd.op   = CELL_INS;
						cnt_next = count_q + 1'b1;
					end
				end
				MODE_DELETE: begin
					res_now = 1'b1;
					if (pos_ext >= cnt_ext) begin
						res_stat = ST_RANGE;
					end else begin
						cmd.op   = CELL_DEL;
						cnt_next = count_q - 1'b1;
					end
				end
				MODE_SEARCH: begin
					go_scan = 1'b1;
				end
				MODE_SORT: begin
					if (count_q < CNT_W'(2)) begin
						res_now = 1'b1;
					end else begin
						go_sort = 1'b1;
					end
				end
				MODE_CLEAR: begin
					res_now  = 1'b1;
					cnt_next = '0;
				end
				default: begin
					res_now = 1'b1;
				end
			endcase
		end
		if (state_q == ST_SRT) begin
			cmd.op = CELL_SORT;
		end
	end

	// the cell row: each cell talks only to its neighbors; an end cell sees its own entry on the open side
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		data_t left_w;
		data_t right_w;
		if (i == 0) begin : g_first
			assign left_w = row[i];
		end else begin : g_mid_l
			assign left_w = row[i-1];
		end
		if (i == TABLE_DEPTH - 1) begin : g_last
			assign right_w = row[i];
		end else begin : g_mid_r
			assign right_w = row[i+1];
		end
		ovt_cell u_cell (
			.clk   (clk),
			.idx   (IDX_W'(i)),
			.cmd   (cmd),
			.left  (left_w),
			.right (right_w),
			.entry (row[i]),
			.match (mvec[i])
		);
	end

	// control: sequencer, scan, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			ph_q        <= '0;
			idx_q       <= '0;
			mvec_q      <= '0;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
			found_q     <= '0;
			ecnt_q      <= '0;
		end else begin
			// drop the result once it is transferred, unless a new one replaces it
			if (out_valid_q && out_ready && !res_now) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (res_now) begin
						count_q     <= cnt_next;
						out_valid_q <= 1'b1;
						status_q    <= res_stat;
						found_q     <= '0;
						ecnt_q      <= ECNT_W'(cnt_next);
					end else if (go_scan) begin
						mvec_q  <= mvec;
						idx_q   <= '0;
						state_q <= ST_SCAN;
					end else if (go_sort) begin
						ph_q    <= '0;
						state_q <= ST_SRT;
					end
				end
				ST_SRT: begin
					// advance one phase; the last phase also posts the result
					if (ph_q == count_q - 1'b1) begin
						out_valid_q <= 1'b1;
						status_q    <= ST_OK;
						found_q     <= '0;
						ecnt_q      <= ECNT_W'(count_q);
						state_q     <= ST_IDLE;
					end else begin
						ph_q <= ph_q + 1'b1;
					end
				end
				ST_SCAN: begin
					if (mvec_q == '0) begin
						out_valid_q <= 1'b1;
						status_q    <= ST_MISSING;
						found_q     <= '0;
						ecnt_q      <= ECNT_W'(count_q);
						state_q     <= ST_IDLE;
					end else if (mvec_q[0]) begin
						out_valid_q <= 1'b1;
						status_q    <= ST_OK;
						found_q     <= FIDX_W'(idx_q);
						ecnt_q      <= ECNT_W'(count_q);
						state_q     <= ST_IDLE;
					end else begin
						mvec_q <= mvec_q >> 1;
						idx_q  <= idx_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_index = found_q;
	assign entry_count = ecnt_q;

	// never more entries than slots
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count exceeds table depth");

	// a long operation never runs while a result is still waiting
	a_busy_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !out_valid_q)
		else $error("busy with a result still pending");

	// sort phases stay below the entry count
	a_sort_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SRT) |-> (ph_q < count_q && count_q >= CNT_W'(2)))
		else $error("sort phase out of range");

	// a search transfer starts a scan with the count left alone
	a_search_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && mode == MODE_SEARCH) |=> (state_q == ST_SCAN && $stable(count_q)))
		else $error("search did not start a scan");

endmodule
`default_nettype wire
